>>> hdl/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants for the bus register map target: event codes,
// sequencer states, sample channel codes and scaling coefficients.
// ----------------------------------------------------------------------------
package i2crm_pkg;

   // event codes carried on the request side
   typedef enum logic [2:0] {
      OP_WRITE_START = 3'd0,
      OP_READ_START  = 3'd1,
      OP_BYTE_RX     = 3'd2,
      OP_BYTE_TX     = 3'd3,
      OP_NACK_END    = 3'd4,
      OP_SAMPLE      = 3'd5,
      OP_BUS_ERROR   = 3'd6
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SAMPLE,
      ST_FINISH
   } state_type;

   // the five converter readings of one sample update
   typedef struct packed {
      logic [11:0] temp;
      logic [11:0] i5;
      logic [11:0] i33;
      logic [11:0] v5;
      logic [11:0] vin;
   } raw_set_type;

   // sample channels, in map order
   localparam logic [2:0] CH_VIN  = 3'd0;
   localparam logic [2:0] CH_V5   = 3'd1;
   localparam logic [2:0] CH_I33  = 3'd2;
   localparam logic [2:0] CH_I5   = 3'd3;
   localparam logic [2:0] CH_TEMP = 3'd4;

   // scaling: word = (operand * coef) >> shift
   //   vin  : 3300 * 14.7 / 40960 = 4851 / 4096
   //   v5   : 3300 * 2 / 4096     = 825 / 512
   //   i33  : 3300 / (4096 * 2)   = 825 / 2048
   //   i5   : 3300 / (4096 * 20)  = 165 / 4096
   //   temp : (raw - 620) * 81, kept to 16 bits
   localparam logic [12:0] COEF_VIN   = 13'd4851;
   localparam logic [12:0] COEF_V5    = 13'd825;
   localparam logic [12:0] COEF_I33   = 13'd825;
   localparam logic [12:0] COEF_I5    = 13'd165;
   localparam logic [12:0] COEF_TEMP  = 13'd81;
   localparam logic [3:0]  SHIFT_VIN  = 4'd12;
   localparam logic [3:0]  SHIFT_V5   = 4'd9;
   localparam logic [3:0]  SHIFT_I33  = 4'd11;
   localparam logic [3:0]  SHIFT_I5   = 4'd12;
   localparam logic [3:0]  SHIFT_TEMP = 4'd0;
   localparam logic [15:0] TEMP_OFFSET = 16'd620;

   // last byte step of one sample update (ten bytes, five little-endian words)
   localparam logic [3:0] SAMPLE_LAST_STEP = 4'd9;

   // stream widths
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 16;

endpackage

>>> hdl/i2c_register_map_target.sv
// A plain event passes the finish state into the response register; a read start
// or byte sent passes the read state first (one map memory read), a sample update
// the sample state. A new request is taken only in idle. The sample update is bound
// by the single write port of the map memory, one byte per cycle for ten bytes.
// Reset: synchronous; then a clearing pass zeroes every map entry while no
// request word is taken.
// ----------------------------------------------------------------------------
// i2c_register_map_target
// Byte-level target side of a two-wire bus register map. The map lives in a
// synchronous memory; a small sequencer handles pointer, receive bytes, config
// writes and the sample-update write sweep.
// ----------------------------------------------------------------------------
module i2c_register_map_target #(
   parameter int MAP_DEPTH    = 16,
   parameter int CONFIG_INDEX = 0,
   parameter int MEAS_BASE    = 2,
   parameter int RX_LIMIT     = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request side
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: data_byte[7:0], raw_vin[19:8], raw_v5[31:20], raw_i33[43:32],
   //        raw_i5[55:44], raw_temp[67:56], zero fill [71:68]
   input  logic [i2crm_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // tuser: operation[2:0]
   input  logic [2:0]                             req_tuser,
   // response side
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata: read_data[7:0], led_on[8], zero fill [15:9]
   output logic [i2crm_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // tuser: read_valid[0]
   output logic                                   rsp_tuser
);
   import i2crm_pkg::*;

   localparam int AW = $clog2(MAP_DEPTH);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(MAP_DEPTH - 1);
   localparam bit CFG_IN_MAP = (CONFIG_INDEX < MAP_DEPTH);
   localparam logic [AW-1:0] CFG_ADDR = AW'(CONFIG_INDEX % MAP_DEPTH);

   // map memory
   logic [7:0]    map_mem [MAP_DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_q_ff;

   // sequencer and state registers
   state_type   state_ff, state_in;
   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;
   logic [3:0]  step_ff, step_in;
   raw_set_type raw_ff, raw_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic [3:0]  rx_count_ff, rx_count_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic        led_ff, led_in;
   logic        rd_ok_ff, rd_ok_in;
   logic [7:0]  res_data_ff, res_data_in;
   logic        res_read_ff, res_read_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_led_ff, rsp_led_in;
   logic        rsp_read_ff, rsp_read_in;

   // request fields
   logic        accept;
   op_type      acc_op;
   logic [7:0]  acc_byte;
   raw_set_type acc_raw;

   // helpers
   logic        out_free;
   logic        ptr_ok;
   logic [8:0]  ptr_inc;
   logic [7:0]  ptr_next;
   logic        ptr_next_ok;
   logic        cfg_write;
   logic [15:0] sample_word;
   logic [7:0]  sample_byte;
   logic [8:0]  sample_addr;
   logic        sample_in_map;

   assign accept   = req_tvalid && req_tready;
   assign acc_op   = op_type'(req_tuser);
   assign acc_byte = req_tdata[7:0];
   assign acc_raw  = raw_set_type'(req_tdata[67:8]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // pointer range and auto increment with wrap
   assign ptr_ok      = {1'b0, ptr_ff} < 9'(MAP_DEPTH);
   assign ptr_inc     = {1'b0, ptr_ff} + 9'd1;
   assign ptr_next    = (ptr_inc >= 9'(MAP_DEPTH)) ? 8'd0 : ptr_inc[7:0];
   assign ptr_next_ok = {1'b0, ptr_next} < 9'(MAP_DEPTH);

   // config write on a two-byte write ending with nack
   assign cfg_write = CFG_IN_MAP && (rx_count_ff == 4'd2) &&
                      (first_ff == 8'(CONFIG_INDEX));

   // sample sweep: one byte per step, low byte first
   i2crm_scale u_scale (
      .raw_set (raw_ff),
      .chan    (step_ff[3:1]),
      .word    (sample_word)
   );
   assign sample_byte   = step_ff[0] ? sample_word[15:8] : sample_word[7:0];
   assign sample_addr   = 9'(MEAS_BASE) + 9'(step_ff);
   assign sample_in_map = sample_addr < 9'(MAP_DEPTH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_cnt_ff == LAST_ENTRY) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (acc_op)
                  OP_READ_START, OP_BYTE_TX: state_in = ST_READ;
                  OP_SAMPLE:                 state_in = ST_SAMPLE;
                  default:                   state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ: state_in = ST_FINISH;
         ST_SAMPLE: begin
            if (step_ff == SAMPLE_LAST_STEP) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake and memory port controls (ready is high in idle)
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = clear_cnt_ff;
      mem_wdata  = 8'd0;
      mem_re     = 1'b0;
      mem_raddr  = ptr_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (acc_op)
                  OP_READ_START: begin
                     mem_re    = ptr_ok;
                     mem_raddr = ptr_ff[AW-1:0];
                  end
                  OP_BYTE_TX: begin
                     mem_re    = ptr_next_ok;
                     mem_raddr = ptr_next[AW-1:0];
                  end
                  OP_NACK_END: begin
                     if (rx_count_ff != 4'd1 && cfg_write) begin
                        mem_we    = 1'b1;
                        mem_waddr = CFG_ADDR;
                        mem_wdata = second_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SAMPLE: begin
            mem_we    = sample_in_map;
            mem_waddr = sample_addr[AW-1:0];
            mem_wdata = sample_byte;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      step_in      = step_ff;
      raw_in       = raw_ff;
      ptr_in       = ptr_ff;
      rx_count_in  = rx_count_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      led_in       = led_ff;
      rd_ok_in     = rd_ok_ff;
      res_data_in  = res_data_ff;
      res_read_in  = res_read_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_led_in   = rsp_led_ff;
      rsp_read_in  = rsp_read_ff;

      // response register drains independently
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               res_data_in = 8'd0;
               res_read_in = 1'b0;
               step_in     = 4'd0;
               case (acc_op)
                  OP_WRITE_START: rx_count_in = 4'd0;
                  OP_READ_START: begin
                     res_read_in = 1'b1;
                     rd_ok_in    = ptr_ok;
                  end
                  OP_BYTE_RX: begin
                     if (rx_count_ff < 4'(RX_LIMIT)) begin
                        if (rx_count_ff == 4'd0) first_in = acc_byte;
                        else if (rx_count_ff == 4'd1) second_in = acc_byte;
                        rx_count_in = rx_count_ff + 4'd1;
                     end
                  end
                  OP_BYTE_TX: begin
                     res_read_in = 1'b1;
                     ptr_in      = ptr_next;
                     rd_ok_in    = ptr_next_ok;
                  end
                  OP_NACK_END: begin
                     if (rx_count_ff == 4'd1) ptr_in = first_ff;
                     else if (cfg_write) led_in = second_ff[0];
                  end
                  OP_SAMPLE: raw_in = acc_raw;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            res_data_in = rd_ok_ff ? mem_q_ff : 8'd0;
         end
         ST_SAMPLE: begin
            step_in = step_ff + 4'd1;
            if (sample_in_map && sample_addr == 9'(CONFIG_INDEX)) led_in = sample_byte[0];
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_led_in   = led_ff;
               rsp_read_in  = res_read_ff;
            end
         end
         default: ;
      endcase
   end

   // map memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_q_ff <= map_mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         ptr_ff       <= 8'd0;
         rx_count_ff  <= 4'd0;
         first_ff     <= 8'd0;
         second_ff    <= 8'd0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         ptr_ff       <= ptr_in;
         rx_count_ff  <= rx_count_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      raw_ff      <= raw_in;
      rd_ok_ff    <= rd_ok_in;
      res_data_ff <= res_data_in;
      res_read_ff <= res_read_in;
      rsp_data_ff <= rsp_data_in;
      rsp_led_ff  <= rsp_led_in;
      rsp_read_ff <= rsp_read_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_led_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_read_ff;

endmodule

>>> hdl/i2crm_scale.sv
// ----------------------------------------------------------------------------
// i2crm_scale
// Fixed-point scaling of one converter reading to its map word. One shared
// constant-coefficient multiplier, followed by a channel-dependent shift.
// ----------------------------------------------------------------------------
module i2crm_scale (
   input  i2crm_pkg::raw_set_type raw_set,
   input  logic [2:0]             chan,
   output logic [15:0]            word
);
   import i2crm_pkg::*;

   logic [15:0] operand;
   logic [12:0] coef;
   logic [3:0]  shift;
   logic [28:0] product;

   // pick reading and coefficient for this channel
   always_comb begin
      operand = 16'd0;
      coef    = 13'd0;
      shift   = 4'd0;
      case (chan)
         CH_VIN: begin
            operand = {4'd0, raw_set.vin};
            coef    = COEF_VIN;
            shift   = SHIFT_VIN;
         end
         CH_V5: begin
            operand = {4'd0, raw_set.v5};
            coef    = COEF_V5;
            shift   = SHIFT_V5;
         end
         CH_I33: begin
            operand = {4'd0, raw_set.i33};
            coef    = COEF_I33;
            shift   = SHIFT_I33;
         end
         CH_I5: begin
            operand = {4'd0, raw_set.i5};
            coef    = COEF_I5;
            shift   = SHIFT_I5;
         end
         CH_TEMP: begin
            // offset wraps modulo 2^16, as does the word taken from the product
            operand = {4'd0, raw_set.temp} - TEMP_OFFSET;
            coef    = COEF_TEMP;
            shift   = SHIFT_TEMP;
         end
         default: begin
            operand = 16'd0;
            coef    = 13'd0;
            shift   = 4'd0;
         end
      endcase
   end

   assign product = 29'(operand) * 29'(coef);
   assign word    = 16'(product >> shift);

endmodule
